// ===== design/rbx_pkg.sv =====
package rbx_pkg;

   // payload widths
   localparam int CompW   = 18;
   localparam int AlphaW  = 32;
   localparam int ThrW    = 17;
   localparam int TsqW    = 2 * ThrW;

   // internal widths of the exact arithmetic
   localparam int YaW     = CompW + AlphaW;
   localparam int CrossW  = YaW + 1;
   localparam int EyW     = 2 * CompW;
   localparam int DotW    = EyW + 2;
   localparam int DyW     = DotW + CompW;
   localparam int VecW    = 58;
   localparam int MagW    = VecW - 1;
   localparam int RcW     = VecW - 16;
   localparam int RpW     = VecW - 32;
   localparam int RndW    = 17;
   localparam int RsqW    = 2 * RndW;
   localparam int RsumW   = RsqW + 2;
   localparam int NormB   = 30;
   localparam int MsqW    = 2 * NormB;
   localparam int SqW     = MsqW + 2;
   localparam int RootW   = SqW / 2;
   localparam int SqrtSteps = SqW / 2 + 1;
   localparam int AccW    = SqW + 1;
   localparam int QuotW   = 17;
   localparam int NumW    = NormB + 16 + 1;
   localparam int RemW    = RootW;
   localparam int ShW     = 5;

   localparam int FrontDepth = 7;
   localparam int PrepDepth  = 5;

   typedef logic signed [CompW-1:0]  comp_type;
   typedef logic signed [AlphaW-1:0] alpha_type;

   typedef logic [1:0] case_type;
   localparam case_type CASE_CROSS = 2'd0;
   localparam case_type CASE_PROJ  = 2'd1;
   localparam case_type CASE_FALL  = 2'd2;

   localparam comp_type ONE_Q16 = 18'sd65536;

   // side information that travels with an item through the normaliser
   typedef struct packed {
      logic [2:0]             neg;
      case_type               kase;
      logic [2:0][CompW-1:0]  fb;
   } side_type;

   typedef struct packed {
      side_type               side;
      logic [2:0][NormB-1:0]  m;
   } tag_type;

   // magnitude of a signed vector component
   function automatic logic [MagW-1:0] vmag(input logic signed [VecW-1:0] v);
      logic signed [VecW-1:0] n;
      n = -v;
      return v[VecW-1] ? n[MagW-1:0] : v[MagW-1:0];
   endfunction

   // right shift that brings the largest magnitude below 2^30
   function automatic logic [ShW-1:0] norm_shift(input logic [MagW-1:0] x);
      logic [ShW:0] bl;
      bl = '0;
      for (int i = 0; i < MagW; i++) begin
         if (x[i]) bl = (ShW + 1)'(i + 1);
      end
      if (bl > (ShW + 1)'(NormB)) return ShW'(bl - (ShW + 1)'(NormB));
      return '0;
   endfunction

endpackage

// ===== design/rbx_if.sv =====
interface rbx_req_if import rbx_pkg::*; ();
   logic      valid;
   logic      ready;
   comp_type  yc_x;
   comp_type  yc_y;
   comp_type  yc_z;
   alpha_type alpha_x;
   alpha_type alpha_y;
   alpha_type alpha_z;
   comp_type  est_axis_x;
   comp_type  est_axis_y;
   comp_type  est_axis_z;
   comp_type  fallback_x;
   comp_type  fallback_y;
   comp_type  fallback_z;

   modport source (output valid, yc_x, yc_y, yc_z, alpha_x, alpha_y, alpha_z,
                   est_axis_x, est_axis_y, est_axis_z, fallback_x, fallback_y, fallback_z,
                   input ready);
   modport sink (input valid, yc_x, yc_y, yc_z, alpha_x, alpha_y, alpha_z,
                 est_axis_x, est_axis_y, est_axis_z, fallback_x, fallback_y, fallback_z,
                 output ready);
endinterface

interface rbx_rsp_if import rbx_pkg::*; ();
   logic      valid;
   logic      ready;
   comp_type  axis_out_x;
   comp_type  axis_out_y;
   comp_type  axis_out_z;
   case_type  case_taken;

   modport source (output valid, axis_out_x, axis_out_y, axis_out_z, case_taken,
                   input ready);
   modport sink (input valid, axis_out_x, axis_out_y, axis_out_z, case_taken,
                 output ready);
endinterface

// ===== design/robust_body_x_axis.sv =====
// Robust body x axis, signed Q2.16 (alpha signed Q16.16). Each beat carries y_C, alpha, the
// estimated body x axis and the fallback axis x_C; the block returns y_C x alpha
// normalised when its norm is at or above csr_write_data's threshold
// (case_taken CASE_CROSS), otherwise the estimate with its y_C part removed,
// normalised (CASE_PROJ), or, when that is also near zero, the fallback axis
// saturated to +-1.0 (CASE_FALL). Components of the result stay within +-1.0.
// The pipeline takes one beat per clock while rsp is not stalled; its depth comes mainly
// from the 32-stage square root and the 18-stage divider of the normaliser. When rsp is
// stalled the whole pipeline holds and req.ready drops. The threshold register resets to 7
// and should be written only while no beat is in flight.
module robust_body_x_axis import rbx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [ThrW-1:0]   csr_write_data,
   rbx_req_if.sink           req,
   rbx_rsp_if.source         rsp
);

   logic en;

   // threshold register and its square
   logic [ThrW-1:0] thr_ff;
   logic [TsqW-1:0] tsq_ff;
   logic [TsqW-1:0] tsq_in;

   assign tsq_in = TsqW'(thr_ff) * TsqW'(thr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrW'(7);
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      tsq_ff <= tsq_in;
   end

   // pipeline advances unless the output beat is held
   logic ov_ff;
   assign en = !ov_ff || rsp.ready;

   logic                 fr_valid;
   logic [2:0][VecW-1:0] fr_vec;
   side_type             fr_side;

   rbx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .tsq      (tsq_ff),
      .req      (req),
      .fr_valid (fr_valid),
      .fr_vec   (fr_vec),
      .fr_side  (fr_side)
   );

   logic           pr_valid;
   logic [SqW-1:0] pr_n2;
   tag_type        pr_tag;

   rbx_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .fr_valid (fr_valid),
      .fr_vec   (fr_vec),
      .fr_side  (fr_side),
      .pr_valid (pr_valid),
      .pr_n2    (pr_n2),
      .pr_tag   (pr_tag)
   );

   logic             rt_valid;
   logic [RootW-1:0] rt_root;
   tag_type          rt_tag;

   rbx_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .sq_valid (pr_valid),
      .sq_n2    (pr_n2),
      .sq_tag   (pr_tag),
      .rt_valid (rt_valid),
      .rt_root  (rt_root),
      .rt_tag   (rt_tag)
   );

   logic                  qt_valid;
   logic [2:0][QuotW-1:0] qt_quot;
   side_type              qt_side;

   rbx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .dv_valid (rt_valid),
      .dv_root  (rt_root),
      .dv_tag   (rt_tag),
      .qt_valid (qt_valid),
      .qt_quot  (qt_quot),
      .qt_side  (qt_side)
   );

   // output register: apply signs or pick the fallback
   comp_type axis_in [3];
   comp_type axis_ff [3];
   case_type kase_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (qt_side.kase == CASE_FALL) axis_in[i] = comp_type'(qt_side.fb[i]);
         else if (qt_side.neg[i]) axis_in[i] = -comp_type'(qt_quot[i]);
         else axis_in[i] = comp_type'(qt_quot[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) axis_ff[i] <= axis_in[i];
         kase_ff <= qt_side.kase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= qt_valid;
      end
   end

   assign rsp.valid      = ov_ff;
   assign rsp.axis_out_x = axis_ff[0];
   assign rsp.axis_out_y = axis_ff[1];
   assign rsp.axis_out_z = axis_ff[2];
   assign rsp.case_taken = kase_ff;

`ifndef SYNTHESIS
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.axis_out_x <= ONE_Q16 && rsp.axis_out_x >= -ONE_Q16 &&
                     rsp.axis_out_y <= ONE_Q16 && rsp.axis_out_y >= -ONE_Q16 &&
                     rsp.axis_out_z <= ONE_Q16 && rsp.axis_out_z >= -ONE_Q16))
      else $error("result component beyond unit range");

   a_case_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.case_taken == CASE_CROSS || rsp.case_taken == CASE_PROJ ||
                     rsp.case_taken == CASE_FALL))
      else $error("bad case code on result beat");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("request taken while result held");

   a_divider_bound: assert property (@(posedge clock) disable iff (reset)
      qt_valid |-> (qt_quot[0] <= QuotW'(65536) && qt_quot[1] <= QuotW'(65536) &&
                    qt_quot[2] <= QuotW'(65536)))
      else $error("quotient above one");
`endif

endmodule

// ===== design/rbx_front.sv =====
module rbx_front import rbx_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [TsqW-1:0]        tsq,
   rbx_req_if.sink                req,
   output logic                   fr_valid,
   output logic [2:0][VecW-1:0]   fr_vec,
   output side_type               fr_side
);

   logic [FrontDepth-2:0] v_ff;

   assign req.ready = en;

   // stage 1: cross and dot products
   logic signed [YaW-1:0] ya_in [6];
   logic signed [YaW-1:0] ya_ff [6];
   logic signed [EyW-1:0] ey_in [3];
   logic signed [EyW-1:0] ey_ff [3];
   comp_type y_in [3];
   comp_type e_in [3];
   comp_type f_in [3];
   comp_type y1_ff [3];
   comp_type e1_ff [3];
   comp_type fb1_ff [3];

   always_comb begin
      y_in[0] = req.yc_x;
      y_in[1] = req.yc_y;
      y_in[2] = req.yc_z;
      e_in[0] = req.est_axis_x;
      e_in[1] = req.est_axis_y;
      e_in[2] = req.est_axis_z;
      // fallback saturates to plus or minus one
      f_in[0] = req.fallback_x;
      f_in[1] = req.fallback_y;
      f_in[2] = req.fallback_z;
      for (int i = 0; i < 3; i++) begin
         if (f_in[i] > ONE_Q16) f_in[i] = ONE_Q16;
         else if (f_in[i] < -ONE_Q16) f_in[i] = -ONE_Q16;
         ey_in[i] = e_in[i] * y_in[i];
      end
      ya_in[0] = req.yc_y * req.alpha_z;
      ya_in[1] = req.yc_z * req.alpha_y;
      ya_in[2] = req.yc_z * req.alpha_x;
      ya_in[3] = req.yc_x * req.alpha_z;
      ya_in[4] = req.yc_x * req.alpha_y;
      ya_in[5] = req.yc_y * req.alpha_x;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) ya_ff[i] <= ya_in[i];
         for (int i = 0; i < 3; i++) begin
            ey_ff[i]  <= ey_in[i];
            y1_ff[i]  <= y_in[i];
            e1_ff[i]  <= e_in[i];
            fb1_ff[i] <= f_in[i];
         end
      end
   end

   // stage 2: cross vector and dot sum
   logic signed [CrossW-1:0] c_in [3];
   logic signed [CrossW-1:0] c2_ff [3];
   logic signed [DotW-1:0]   d_in;
   logic signed [DotW-1:0]   d2_ff;
   comp_type y2_ff [3];
   comp_type e2_ff [3];
   comp_type fb2_ff [3];

   always_comb begin
      c_in[0] = CrossW'(ya_ff[0]) - CrossW'(ya_ff[1]);
      c_in[1] = CrossW'(ya_ff[2]) - CrossW'(ya_ff[3]);
      c_in[2] = CrossW'(ya_ff[4]) - CrossW'(ya_ff[5]);
      d_in = DotW'(ey_ff[0]) + DotW'(ey_ff[1]) + DotW'(ey_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff <= d_in;
         for (int i = 0; i < 3; i++) begin
            c2_ff[i]  <= c_in[i];
            y2_ff[i]  <= y1_ff[i];
            e2_ff[i]  <= e1_ff[i];
            fb2_ff[i] <= fb1_ff[i];
         end
      end
   end

   // stage 3: rounded cross magnitudes, projection products
   logic signed [VecW-1:0] c3_ff [3];
   logic [RcW-1:0]         rc_in [3];
   logic [RcW-1:0]         rc3_ff [3];
   logic signed [DyW-1:0]  dy_in [3];
   logic signed [DyW-1:0]  dy3_ff [3];
   comp_type e3_ff [3];
   comp_type fb3_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rc_in[i] = RcW'((VecW'(vmag(VecW'(c2_ff[i]))) + (VecW'(1) << 15)) >> 16);
         dy_in[i] = d2_ff * y2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c3_ff[i]  <= VecW'(c2_ff[i]);
            rc3_ff[i] <= rc_in[i];
            dy3_ff[i] <= dy_in[i];
            e3_ff[i]  <= e2_ff[i];
            fb3_ff[i] <= fb2_ff[i];
         end
      end
   end

   // stage 4: cross squares, projection vector
   logic [RsqW-1:0]        sqc_in [3];
   logic [RsqW-1:0]        sqc4_ff [3];
   logic                   bigc_in;
   logic                   bigc4_ff;
   logic signed [VecW-1:0] p_in [3];
   logic signed [VecW-1:0] p4_ff [3];
   logic signed [VecW-1:0] c4_ff [3];
   comp_type fb4_ff [3];

   always_comb begin
      bigc_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sqc_in[i] = rc3_ff[i][RndW-1:0] * rc3_ff[i][RndW-1:0];
         bigc_in = bigc_in | (|rc3_ff[i][RcW-1:RndW]);
         p_in[i] = (VecW'(e3_ff[i]) <<< 32) - VecW'(dy3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bigc4_ff <= bigc_in;
         for (int i = 0; i < 3; i++) begin
            sqc4_ff[i] <= sqc_in[i];
            p4_ff[i]   <= p_in[i];
            c4_ff[i]   <= c3_ff[i];
            fb4_ff[i]  <= fb3_ff[i];
         end
      end
   end

   // stage 5: cross test, rounded projection magnitudes
   logic                   nearc_in;
   logic                   nearc5_ff;
   logic [RpW-1:0]         rp_in [3];
   logic [RpW-1:0]         rp5_ff [3];
   logic signed [VecW-1:0] c5_ff [3];
   logic signed [VecW-1:0] p5_ff [3];
   comp_type fb5_ff [3];

   always_comb begin
      nearc_in = !bigc4_ff &&
                 (RsumW'(sqc4_ff[0]) + RsumW'(sqc4_ff[1]) + RsumW'(sqc4_ff[2]) < RsumW'(tsq));
      for (int i = 0; i < 3; i++) begin
         rp_in[i] = RpW'((VecW'(vmag(p4_ff[i])) + (VecW'(1) << 31)) >> 32);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nearc5_ff <= nearc_in;
         for (int i = 0; i < 3; i++) begin
            rp5_ff[i] <= rp_in[i];
            c5_ff[i]  <= c4_ff[i];
            p5_ff[i]  <= p4_ff[i];
            fb5_ff[i] <= fb4_ff[i];
         end
      end
   end

   // stage 6: projection squares
   logic [RsqW-1:0]        sqp_in [3];
   logic [RsqW-1:0]        sqp6_ff [3];
   logic                   bigp_in;
   logic                   bigp6_ff;
   logic                   nearc6_ff;
   logic signed [VecW-1:0] c6_ff [3];
   logic signed [VecW-1:0] p6_ff [3];
   comp_type fb6_ff [3];

   always_comb begin
      bigp_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sqp_in[i] = rp5_ff[i][RndW-1:0] * rp5_ff[i][RndW-1:0];
         bigp_in = bigp_in | (|rp5_ff[i][RpW-1:RndW]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bigp6_ff  <= bigp_in;
         nearc6_ff <= nearc5_ff;
         for (int i = 0; i < 3; i++) begin
            sqp6_ff[i] <= sqp_in[i];
            c6_ff[i]   <= c5_ff[i];
            p6_ff[i]   <= p5_ff[i];
            fb6_ff[i]  <= fb5_ff[i];
         end
      end
   end

   // stage 7: case choice and vector select
   logic                 nearp_in;
   case_type             kase_in;
   logic [2:0][VecW-1:0] vec_in;
   side_type             side_in;
   logic [2:0][VecW-1:0] vec7_ff;
   side_type             side7_ff;

   always_comb begin
      nearp_in = !bigp6_ff &&
                 (RsumW'(sqp6_ff[0]) + RsumW'(sqp6_ff[1]) + RsumW'(sqp6_ff[2]) < RsumW'(tsq));
      if (!nearc6_ff) kase_in = CASE_CROSS;
      else if (!nearp_in) kase_in = CASE_PROJ;
      else kase_in = CASE_FALL;
      side_in.neg  = '0;
      side_in.kase = kase_in;
      for (int i = 0; i < 3; i++) begin
         vec_in[i] = (kase_in == CASE_CROSS) ? c6_ff[i] : p6_ff[i];
         side_in.fb[i] = fb6_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec7_ff  <= vec_in;
         side7_ff <= side_in;
      end
   end

   // valid bits travel with the beat
   logic fv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         fv_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[FrontDepth-3:0], req.valid};
         fv_ff <= v_ff[FrontDepth-2];
      end
   end

   assign fr_valid = fv_ff;
   assign fr_vec   = vec7_ff;
   assign fr_side  = side7_ff;

endmodule

// ===== design/rbx_prep.sv =====
module rbx_prep import rbx_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 fr_valid,
   input  logic [2:0][VecW-1:0] fr_vec,
   input  side_type             fr_side,
   output logic                 pr_valid,
   output logic [SqW-1:0]       pr_n2,
   output tag_type              pr_tag
);

   logic [PrepDepth-1:0] v_ff;

   // stage 1: magnitudes and signs
   logic [MagW-1:0] m1_ff [3];
   side_type        s1_ff;
   side_type        s1_in;

   always_comb begin
      s1_in = fr_side;
      for (int i = 0; i < 3; i++) s1_in.neg[i] = fr_vec[i][VecW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         for (int i = 0; i < 3; i++) m1_ff[i] <= vmag(fr_vec[i]);
      end
   end

   // stage 2: common shift count
   logic [ShW-1:0]  k_in;
   logic [ShW-1:0]  k2_ff;
   logic [MagW-1:0] m2_ff [3];
   side_type        s2_ff;

   assign k_in = norm_shift(m1_ff[0] | m1_ff[1] | m1_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         k2_ff <= k_in;
         s2_ff <= s1_ff;
         for (int i = 0; i < 3; i++) m2_ff[i] <= m1_ff[i];
      end
   end

   // stage 3: shift magnitudes below 2^30
   logic [2:0][NormB-1:0] m_in;
   logic [2:0][NormB-1:0] m3_ff;
   side_type              s3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) m_in[i] = NormB'(m2_ff[i] >> k2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_ff <= m_in;
         s3_ff <= s2_ff;
      end
   end

   // stage 4: squares
   logic [MsqW-1:0]       sq_in [3];
   logic [MsqW-1:0]       sq4_ff [3];
   logic [2:0][NormB-1:0] m4_ff;
   side_type              s4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) sq_in[i] = m3_ff[i] * m3_ff[i];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m4_ff <= m3_ff;
         s4_ff <= s3_ff;
         for (int i = 0; i < 3; i++) sq4_ff[i] <= sq_in[i];
      end
   end

   // stage 5: squared norm
   logic [SqW-1:0] n2_in;
   logic [SqW-1:0] n2_5_ff;
   tag_type        t5_ff;

   assign n2_in = SqW'(sq4_ff[0]) + SqW'(sq4_ff[1]) + SqW'(sq4_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         n2_5_ff    <= n2_in;
         t5_ff.side <= s4_ff;
         t5_ff.m    <= m4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[PrepDepth-2:0], fr_valid};
      end
   end

   assign pr_valid = v_ff[PrepDepth-1];
   assign pr_n2    = n2_5_ff;
   assign pr_tag   = t5_ff;

endmodule

// ===== design/rbx_isqrt.sv =====
module rbx_isqrt import rbx_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             sq_valid,
   input  logic [SqW-1:0]   sq_n2,
   input  tag_type          sq_tag,
   output logic             rt_valid,
   output logic [RootW-1:0] rt_root,
   output tag_type          rt_tag
);

   logic [SqW-1:0] x_ff [SqrtSteps];
   logic [AccW-1:0] r_ff [SqrtSteps];
   tag_type        t_ff [SqrtSteps];
   logic [SqrtSteps-1:0] v_ff;

   // one result bit per stage, bit weight 4^(steps-1-j)
   for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
      localparam logic [AccW-1:0] Bit = AccW'(1) << (2 * (SqrtSteps - 1 - j));
      logic [SqW-1:0]  x_cur;
      logic [AccW-1:0] r_cur;
      tag_type         t_cur;
      logic            v_cur;
      logic [AccW-1:0] trial;
      logic [SqW-1:0]  x_in;
      logic [AccW-1:0] r_in;

      if (j == 0) begin : g_first
         assign x_cur = sq_n2;
         assign r_cur = '0;
         assign t_cur = sq_tag;
         assign v_cur = sq_valid;
      end else begin : g_next
         assign x_cur = x_ff[j-1];
         assign r_cur = r_ff[j-1];
         assign t_cur = t_ff[j-1];
         assign v_cur = v_ff[j-1];
      end

      always_comb begin
         trial = r_cur + Bit;
         if (AccW'(x_cur) >= trial) begin
            x_in = SqW'(AccW'(x_cur) - trial);
            r_in = (r_cur >> 1) + Bit;
         end else begin
            x_in = x_cur;
            r_in = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[j] <= x_in;
            r_ff[j] <= r_in;
            t_ff[j] <= t_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_cur;
         end
      end
   end

   assign rt_valid = v_ff[SqrtSteps-1];
   assign rt_root  = r_ff[SqrtSteps-1][RootW-1:0];
   assign rt_tag   = t_ff[SqrtSteps-1];

endmodule

// ===== design/rbx_div.sv =====
module rbx_div import rbx_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   dv_valid,
   input  logic [RootW-1:0]       dv_root,
   input  tag_type                dv_tag,
   output logic                   qt_valid,
   output logic [2:0][QuotW-1:0]  qt_quot,
   output side_type               qt_side
);

   // stage 0: rounded numerators, upper part as start remainder
   logic [NumW-1:0]             num_in [3];
   logic [2:0][RemW-1:0]        rem0_ff;
   logic [2:0][QuotW-1:0]       lo0_ff;
   logic [RootW-1:0]            n0_ff;
   logic                        nz0_ff;
   side_type                    s0_ff;
   logic                        v0_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NumW'(dv_tag.m[i]) << 16) + NumW'(dv_root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem0_ff[i] <= RemW'(num_in[i] >> QuotW);
            lo0_ff[i]  <= num_in[i][QuotW-1:0];
         end
         n0_ff  <= dv_root;
         nz0_ff <= (dv_root != '0);
         s0_ff  <= dv_tag.side;
      end
   end

   logic [2:0][RemW-1:0]  rem_ff [QuotW];
   logic [2:0][QuotW-1:0] lo_ff [QuotW];
   logic [2:0][QuotW-1:0] q_ff [QuotW];
   logic [RootW-1:0]      n_ff [QuotW];
   logic                  nz_ff [QuotW];
   side_type              s_ff [QuotW];
   logic [QuotW-1:0]      v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= dv_valid;
      end
   end

   // restoring division, one quotient bit per stage in each lane
   for (genvar j = 0; j < QuotW; j++) begin : g_step
      logic [2:0][RemW-1:0]  rem_cur;
      logic [2:0][QuotW-1:0] lo_cur;
      logic [2:0][QuotW-1:0] q_cur;
      logic [RootW-1:0]      n_cur;
      logic                  nz_cur;
      side_type              s_cur;
      logic                  v_cur;
      logic [2:0][RemW-1:0]  rem_in;
      logic [2:0][QuotW-1:0] q_in;
      logic [2:0][QuotW-1:0] lo_in;
      logic [RemW:0]         trial [3];

      if (j == 0) begin : g_first
         assign rem_cur = rem0_ff;
         assign lo_cur  = lo0_ff;
         assign q_cur   = '0;
         assign n_cur   = n0_ff;
         assign nz_cur  = nz0_ff;
         assign s_cur   = s0_ff;
         assign v_cur   = v0_ff;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign lo_cur  = lo_ff[j-1];
         assign q_cur   = q_ff[j-1];
         assign n_cur   = n_ff[j-1];
         assign nz_cur  = nz_ff[j-1];
         assign s_cur   = s_ff[j-1];
         assign v_cur   = v_ff[j-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            trial[i] = {rem_cur[i], lo_cur[i][QuotW-1]};
            lo_in[i] = lo_cur[i] << 1;
            if (trial[i] >= (RemW + 1)'(n_cur)) begin
               rem_in[i] = RemW'(trial[i] - (RemW + 1)'(n_cur));
               q_in[i]   = {q_cur[i][QuotW-2:0], 1'b1};
            end else begin
               rem_in[i] = RemW'(trial[i]);
               q_in[i]   = {q_cur[i][QuotW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            lo_ff[j]  <= lo_in;
            q_ff[j]   <= q_in;
            n_ff[j]   <= n_cur;
            nz_ff[j]  <= nz_cur;
            s_ff[j]   <= s_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_cur;
         end
      end
   end

   // a zero norm gives the zero vector
   assign qt_valid = v_ff[QuotW-1];
   assign qt_quot  = nz_ff[QuotW-1] ? q_ff[QuotW-1] : '0;
   assign qt_side  = s_ff[QuotW-1];

endmodule

// ===== test/tb.sv =====
module tb import rbx_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [17:0] y[3];
      logic signed [31:0] a[3];
      logic signed [17:0] e[3];
      logic signed [17:0] f[3];
   } axis_req_type;

   typedef struct {
      comp_type x, y, z;
      case_type kase;
   } axis_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [ThrW-1:0] csr_write_data = '0;
   rbx_req_if req();
   rbx_rsp_if rsp();

   robust_body_x_axis dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req(req.sink), .rsp(rsp.source)
   );

   axis_rsp_type expected_axes[$];
   logic [16:0] threshold = 17'd7;
   int errors = 0;
   int hold_off = 0;
   bit no_idle = 0;

   initial forever #2 clock = ~clock;

   initial begin
      #20ms;
      $display("FAIL robust_body_x_axis");
      $finish;
   end

   // rounded Q16.16 magnitude from sh fraction bits
   function automatic logic [63:0] round_mag(logic signed [63:0] v, int sh);
      logic [63:0] m;
      m = v < 0 ? 64'(-v) : 64'(v);
      return (m + (64'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic bit is_near_zero(logic signed [63:0] v[3], int sh, logic [16:0] t);
      logic [63:0] r, sum;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         r = round_mag(v[i], sh);
         if (r >= (64'd1 << 17)) return 0;
         sum += r * r;
      end
      return sum < 64'(t) * 64'(t);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic void unit_vector(logic signed [63:0] v[3], output comp_type o[3]);
      logic [63:0] m[3], mx, n2, n, q;
      int k;
      mx = 0; n2 = 0; k = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      while ((mx >> k) >= (64'd1 << 30)) k++;
      for (int i = 0; i < 3; i++) begin
         m[i] >>= k;
         n2 += m[i] * m[i];
      end
      n = int_sqrt(n2);
      for (int i = 0; i < 3; i++) begin
         q = 0;
         if (n != 0) begin
            q = ((m[i] << 16) + (n >> 1)) / n;
            if (q > 65536) q = 65536;
         end
         o[i] = v[i] < 0 ? comp_type'(-q) : comp_type'(q);
      end
   endfunction

   function automatic axis_rsp_type predict_axis(axis_req_type it);
      logic signed [63:0] y[3], a[3], e[3], c[3], p[3], d, fv;
      comp_type o[3];
      axis_rsp_type r;
      for (int i = 0; i < 3; i++) begin
         y[i] = it.y[i]; a[i] = it.a[i]; e[i] = it.e[i];
      end
      c[0] = y[1] * a[2] - y[2] * a[1];
      c[1] = y[2] * a[0] - y[0] * a[2];
      c[2] = y[0] * a[1] - y[1] * a[0];
      if (!is_near_zero(c, 16, threshold)) begin
         unit_vector(c, o);
         r.kase = CASE_CROSS;
      end else begin
         d = e[0] * y[0] + e[1] * y[1] + e[2] * y[2];
         for (int i = 0; i < 3; i++) p[i] = (e[i] <<< 32) - d * y[i];
         if (!is_near_zero(p, 32, threshold)) begin
            unit_vector(p, o);
            r.kase = CASE_PROJ;
         end else begin
            for (int i = 0; i < 3; i++) begin
               fv = it.f[i];
               if (fv > 65536) fv = 65536;
               if (fv < -65536) fv = -65536;
               o[i] = comp_type'(fv);
            end
            r.kase = CASE_FALL;
         end
      end
      r.x = o[0]; r.y = o[1]; r.z = o[2];
      return r;
   endfunction

   // result beats: random stalls plus a long hold-off when asked
   initial begin
      int w;
      rsp.ready <= 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off > 0) begin
            rsp.ready <= 0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         w = no_idle ? 0 : $urandom_range(0, 14);
         if (w > 0) begin
            rsp.ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock iff rsp.valid);
      end
   end

   // check each result beat against the oldest prediction
   always @(posedge clock) begin
      axis_rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_axes.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            e = expected_axes.pop_front();
            if (rsp.axis_out_x !== e.x) begin
               $error("axis_out_x exp %0d got %0d", e.x, rsp.axis_out_x); errors++;
            end
            if (rsp.axis_out_y !== e.y) begin
               $error("axis_out_y exp %0d got %0d", e.y, rsp.axis_out_y); errors++;
            end
            if (rsp.axis_out_z !== e.z) begin
               $error("axis_out_z exp %0d got %0d", e.z, rsp.axis_out_z); errors++;
            end
            if (rsp.case_taken !== e.kase) begin
               $error("case_taken exp %0d got %0d", e.kase, rsp.case_taken); errors++;
            end
         end
      end
   end

   // valid stays up after an accepted beat until the next beat or a pause
   task automatic send_item(axis_req_type it, bit gap = 1);
      int w;
      w = (gap && !no_idle) ? $urandom_range(0, 14) : 0;
      if (w > 0) begin
         req.valid <= 0;
         repeat (w) @(posedge clock);
      end
      req.valid <= 1;
      req.yc_x <= it.y[0]; req.yc_y <= it.y[1]; req.yc_z <= it.y[2];
      req.alpha_x <= it.a[0]; req.alpha_y <= it.a[1]; req.alpha_z <= it.a[2];
      req.est_axis_x <= it.e[0]; req.est_axis_y <= it.e[1]; req.est_axis_z <= it.e[2];
      req.fallback_x <= it.f[0]; req.fallback_y <= it.f[1]; req.fallback_z <= it.f[2];
      @(posedge clock iff req.ready);
      expected_axes.push_back(predict_axis(it));
   endtask

   task automatic drain();
      req.valid <= 0;
      wait (expected_axes.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_threshold(logic [16:0] t);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= t;
      @(posedge clock);
      csr_write_enable <= 0;
      threshold = t;
   endtask

   function automatic logic signed [17:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 18'(-65536);
         1: return 18'(65536);
         2: return 18'($urandom);
         3: return 18'($urandom_range(0, 40)) - 18'sd20;
         default: return 18'(int'($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   function automatic axis_req_type rand_item();
      axis_req_type it;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         it.y[i] = rand_comp(); it.e[i] = rand_comp(); it.f[i] = rand_comp();
         case ($urandom_range(0, 3))
            0: it.a[i] = $urandom;
            1: it.a[i] = 32'($urandom_range(0, 64)) - 32'sd32;
            default: it.a[i] = int'($urandom_range(0, 1 << 20)) - (1 << 19);
         endcase
      end
      // parallel alpha drives the projection and fallback paths
      if (mode < 3) for (int i = 0; i < 3; i++)
         it.a[i] = it.y[i] * $signed($urandom_range(0, 8) - 4);
      if (mode == 0) for (int i = 0; i < 3; i++)
         it.e[i] = it.y[i] + 18'($urandom_range(0, 4)) - 18'sd2;
      return it;
   endfunction

   function automatic axis_req_type make_item(int yx, int yy, int yz, int ax, int ay, int az,
                                              int ex, int ey, int ez, int fx, int fy, int fz);
      axis_req_type it;
      it.y[0] = 18'(yx); it.y[1] = 18'(yy); it.y[2] = 18'(yz);
      it.a[0] = ax; it.a[1] = ay; it.a[2] = az;
      it.e[0] = 18'(ex); it.e[1] = 18'(ey); it.e[2] = 18'(ez);
      it.f[0] = 18'(fx); it.f[1] = 18'(fy); it.f[2] = 18'(fz);
      return it;
   endfunction

   task automatic test_directed();
      send_item(make_item(65536, 0, 0, 0, 65536, 0, 0, 0, 0, 1, 2, 3));
      send_item(make_item(0, 0, 65536, 0, 0, 65536, 65536, 0, 0, 0, 0, 0));
      send_item(make_item(65536, 0, 0, 65536, 0, 0, 65536, 0, 0, 0, 65536, 0));
      send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, -131072, 131071, -65537));
      send_item(make_item(-131072, -131072, -131072, 32'h7fffffff, 32'h80000000,
                          32'h7fffffff, -131072, 131071, 0, 131071, -131072, 65536));
      send_item(make_item(131071, -131072, 131071, 32'h80000000, 32'h80000000,
                          32'h80000000, 0, 0, 0, 0, 0, 0));
      send_item(make_item(1, 0, 0, 0, 3, 0, 0, 5, 0, 7, 7, 7));
      send_item(make_item(46341, 46341, 0, -46341, 46341, 0, 0, 0, 65536, -65536, 0, 0));
      send_item(make_item(0, 65536, 0, 0, -65536, 0, 3, 0, 4, 0, 0, -65536));
      set_threshold(17'd0);
      send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 9, 9, 9));
      send_item(make_item(65536, 0, 0, 65536, 0, 0, 0, 0, 0, 9, 9, 9));
      set_threshold(17'd65536);
      send_item(make_item(65536, 0, 0, 0, 65535, 0, 0, 65536, 0, 1, 1, 1));
      send_item(make_item(65536, 0, 0, 0, 65536, 0, 0, 0, 0, 1, 1, 1));
      send_item(make_item(65536, 0, 0, 65536, 0, 0, 0, 46341, 46341, 1, 1, 1));
      send_item(make_item(65536, 0, 0, 65536, 0, 0, 65536, 0, 0, -1, 131071, -3));
      set_threshold(17'd7);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 400 == 399) set_threshold(17'($urandom_range(0, 65536)));
         if (i % 200 == 100) no_idle = 1;
         if (i % 200 == 150) no_idle = 0;
         send_item(rand_item());
      end
   endtask

   // receiver holds off while items keep coming, so the pipeline fills
   task automatic test_backpressure();
      no_idle = 1;
      hold_off = 300;
      for (int i = 0; i < 150; i++) send_item(rand_item(), 0);
      no_idle = 0;
      // sender pauses until every result is back
      drain();
      for (int i = 0; i < 20; i++) send_item(rand_item());
   endtask

   initial begin
      req.valid <= 0;
      req.yc_x <= 0; req.yc_y <= 0; req.yc_z <= 0;
      req.alpha_x <= 0; req.alpha_y <= 0; req.alpha_z <= 0;
      req.est_axis_x <= 0; req.est_axis_y <= 0; req.est_axis_z <= 0;
      req.fallback_x <= 0; req.fallback_y <= 0; req.fallback_z <= 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1600);
      set_threshold(17'd65536);
      test_random(100);
      set_threshold(17'd0);
      test_random(100);
      drain();
      if (errors == 0 && expected_axes.size() == 0)
         $display("PASS robust_body_x_axis");
      else
         $display("FAIL robust_body_x_axis");
      $finish;
   end
endmodule
